@@ rtl/cst_pkg.sv @@
// shared types, request codes and id helper for the client session table
package cst_pkg;

    localparam int SLOTS_DEF = 8;

    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_FIND_KEY = 3'd2;
    localparam logic [2:0] REQ_FIND_NUM = 3'd3;
    localparam logic [2:0] REQ_ALLOC    = 3'd4;
    localparam logic [2:0] REQ_RESET    = 3'd5;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [63:0]        network_key;
        logic signed [15:0] player_num;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic               clear_local_key;
        logic               clear_local_num;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [5:0]         slot_index;
        logic [63:0]        key_out;
        logic signed [15:0] num_out;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } t_res;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] num;
        logic [23:0]        colour;
    } t_entry;

    // round-robin id step: wrap, then clamp values below one to one
    function automatic logic [15:0] next_id(input logic [15:0] v);
        logic [15:0] c;
        c = v + 16'd1;
        if ($signed(c) < 16'sd1) begin
            c = 16'd1;
        end
        return c;
    endfunction

endpackage

@@ rtl/client_session_table.sv @@
// client session table: request sequencer over the entry memory
//
// Input channel: an item on i_req is taken at a rising edge with start high and busy low.
// Result channel: every item gives one result on o_res, shown for one cycle while o_done
// is high; there is no backpressure, the receiver takes it in that cycle.
// Work per request type, from the accepting edge to the result cycle:
//   add and unused request types: result in the cycle after (free slot from the valid flags)
//   remove, find by key, find by id: walk up from slot 0 to the first hit or the last slot
//   reset: read-modify-write of slot 0
//   allocate id: one full slot walk per taken id, restarted from slot 0 each time
// Each slot visit is a read of the entry memory (S_READ) followed by a compare (S_CHECK).
// One item is in work at a time; busy is high from the accepting edge until the result
// cycle for the walking requests (add and unused types leave it low), and the next item
// may be given in the result cycle itself.
// Reset (i_rst_n low, synchronous) clears all valid flags, the id counter and the
// memory's written flags, so every entry reads as zero until written; no sweep is run.
module client_session_table #(
    parameter int SLOTS = cst_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cst_pkg::t_req i_req,
    output logic          o_done,
    output cst_pkg::t_res o_res
);
    import cst_pkg::*;

    localparam int             AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0]  LAST = AW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [15:0]      r_last, n_last;
    logic [15:0]      r_start_id, n_start_id;
    logic             r_done, n_done;
    t_res             r_res, n_res;
    t_req             r_req, n_req;

    logic             mem_rd_en;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    t_entry           mem_wr_data;
    t_entry           mem_rd_data;

    logic             w_free_hit;
    logic [AW-1:0]    w_free_idx;
    logic [15:0]      w_next;
    logic             w_match;
    logic             w_hit;

    cst_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    // lowest free slot
    always_comb begin
        w_free_hit = 1'b0;
        w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_hit = 1'b1;
                w_free_idx = AW'(i);
            end
        end
    end

    assign w_next = next_id(r_last);

    always_comb begin
        case (r_req.req_type)
            REQ_FIND_NUM: w_match = (mem_rd_data.num == r_req.player_num);
            REQ_ALLOC:    w_match = (mem_rd_data.key == {48'd0, r_last});
            default:      w_match = (mem_rd_data.key == r_req.network_key);
        endcase
    end

    assign w_hit = r_valid[r_idx] && w_match;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_last      = r_last;
        n_start_id  = r_start_id;
        n_done      = 1'b0;
        n_res       = r_res;
        n_req       = r_req;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_idx;
        mem_wr_data = mem_rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_idx = '0;
                    n_res = '0;
                    case (i_req.req_type)
                        REQ_ADD: begin
                            n_done = 1'b1;
                            if (w_free_hit) begin
                                mem_wr_en          = 1'b1;
                                mem_wr_addr        = w_free_idx;
                                mem_wr_data.key    = i_req.network_key;
                                mem_wr_data.num    = i_req.player_num;
                                mem_wr_data.colour = {i_req.red_in, i_req.green_in,
                                                      i_req.blue_in};
                                n_valid[w_free_idx] = 1'b1;
                                n_res.ok         = 1'b1;
                                n_res.slot_index = 6'(w_free_idx);
                                n_res.key_out    = i_req.network_key;
                                n_res.num_out    = i_req.player_num;
                                n_res.red_out    = i_req.red_in;
                                n_res.green_out  = i_req.green_in;
                                n_res.blue_out   = i_req.blue_in;
                            end
                        end
                        REQ_REMOVE, REQ_FIND_KEY, REQ_FIND_NUM: begin
                            n_state = S_READ;
                        end
                        REQ_ALLOC: begin
                            n_start_id = r_last;
                            n_last     = w_next;
                            if (w_next == r_last) begin
                                n_done        = 1'b1;
                                n_res.num_out = -16'sd1;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        REQ_RESET: begin
                            n_valid = SLOTS'(1);
                            n_last  = '0;
                            n_state = S_READ;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                mem_rd_en = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                case (r_req.req_type)
                    REQ_RESET: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        if (r_req.clear_local_key) begin
                            mem_wr_data.key = '0;
                        end
                        if (r_req.clear_local_num) begin
                            mem_wr_data.num = '0;
                        end
                        n_res    = '0;
                        n_res.ok = 1'b1;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                    REQ_ALLOC: begin
                        if (w_hit) begin
                            // candidate taken: step the counter and walk again
                            n_last = w_next;
                            n_idx  = '0;
                            if (w_next == r_start_id) begin
                                n_res         = '0;
                                n_res.num_out = -16'sd1;
                                n_done        = 1'b1;
                                n_state       = S_IDLE;
                            end else begin
                                n_state = S_READ;
                            end
                        end else if (r_idx == LAST) begin
                            n_res         = '0;
                            n_res.ok      = 1'b1;
                            n_res.num_out = r_last;
                            n_done        = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        if (w_hit) begin
                            if (r_req.req_type == REQ_REMOVE) begin
                                n_valid[r_idx] = 1'b0;
                            end
                            n_res.ok         = 1'b1;
                            n_res.slot_index = 6'(r_idx);
                            n_res.key_out    = mem_rd_data.key;
                            n_res.num_out    = mem_rd_data.num;
                            n_res.red_out    = mem_rd_data.colour[23:16];
                            n_res.green_out  = mem_rd_data.colour[15:8];
                            n_res.blue_out   = mem_rd_data.colour[7:0];
                            n_done           = 1'b1;
                            n_state          = S_IDLE;
                        end else if (r_idx == LAST) begin
                            n_res   = '0;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= '0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_start_id <= n_start_id;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/cst_mem.sv @@
// entry memory: one write port, one registered read port, never-written entries read as zero
module cst_mem #(
    parameter int SLOTS = cst_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(cst_pkg::SLOTS_DEF)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output cst_pkg::t_entry o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  cst_pkg::t_entry i_wr_data
);
    import cst_pkg::*;

    t_entry             r_mem [SLOTS];
    t_entry             r_rd_data;
    logic [SLOTS-1:0]   r_seen;
    logic               r_rd_seen;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // written flags stand in for the all-zero power-on contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rd_seen <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_seen[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_seen <= r_seen[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_seen ? r_rd_data : '0;

endmodule

@@ rtl/cst_chk.sv @@
// port-level checks for the client session table, bound to the top level
module cst_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input cst_pkg::t_res o_res
);
    import cst_pkg::*;

    // after reset nothing is in work and no result is shown
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("block not idle after reset");

    // an accepted item either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither busy nor done");

    // the end of a busy stretch is the result cycle
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // a failed request reports no slot, no key and zero red and blue colour
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.ok) |-> (o_res.slot_index == 6'd0 && o_res.key_out == 64'd0
                                   && o_res.red_out == 8'd0 && o_res.blue_out == 8'd0))
        else $error("failed result carries entry data");

endmodule

bind client_session_table cst_chk u_cst_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
